FILE: rtl/kwc_pkg.sv
`timescale 1ns / 1ps

package kwc_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int FIELD_WIDTH = 16;
	localparam int NUM_KW      = 5;
	localparam int TOK_CHARS   = 6;
	localparam int TOK_BITS    = TOK_CHARS * 8;
	localparam int LEN_WIDTH   = 3;

	localparam logic [LEN_WIDTH-1:0] TOK_LEN_MAX = LEN_WIDTH'(TOK_CHARS);

	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef enum logic [2:0] {
		KW_INT    = 3'd0,
		KW_RETURN = 3'd1,
		KW_IF     = 3'd2,
		KW_ELSE   = 3'd3,
		KW_WHILE  = 3'd4
	} kw_idx_t;

	// Keywords packed newest character in the low byte, as the token shifts in.
	localparam logic [TOK_BITS-1:0] KW_CHARS [NUM_KW] = '{
		48'h0000_0069_6E74,
		48'h7265_7475_726E,
		48'h0000_0000_6966,
		48'h0000_656C_7365,
		48'h0077_6869_6C65
	};
	localparam logic [LEN_WIDTH-1:0] KW_LEN [NUM_KW] = '{3'd3, 3'd6, 3'd2, 3'd4, 3'd5};

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_word_t;

	typedef struct packed {
		logic [FIELD_WIDTH-1:0] count_int;
		logic [FIELD_WIDTH-1:0] count_return;
		logic [FIELD_WIDTH-1:0] count_if;
		logic [FIELD_WIDTH-1:0] count_else;
		logic [FIELD_WIDTH-1:0] count_while;
	} out_word_t;

	typedef struct packed {
		logic [TOK_BITS-1:0]  chars;
		logic [LEN_WIDTH-1:0] len;
		logic                 too_long;
	} tok_t;

	function automatic logic is_delim(input logic [7:0] c);
		logic d;
		case (c) inside
			8'h20, 8'h09, 8'h0A, 8'h2E, 8'h2C, 8'h3B, 8'h28, 8'h29, 8'h7B, 8'h7D,
			8'h5B, 8'h5D, 8'h3C, 8'h3E, 8'h21, 8'h2B, 8'h2D, 8'h3D, 8'h2A, 8'h2F:
				d = 1'b1;
			default: d = 1'b0;
		endcase
		return d;
	endfunction

endpackage

FILE: rtl/kwc_token.sv
`timescale 1ns / 1ps

module kwc_token import kwc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [7:0]        text_byte,
	input  logic              last,
	output logic [NUM_KW-1:0] hit
);

	tok_t tok_q;
	logic ended_q;

	tok_t tok_app;
	tok_t tok_sel;
	tok_t tok_d;
	logic is_zero;
	logic brk;
	logic do_close;

	always_comb begin
		is_zero = (text_byte == 8'h00);
		brk     = !ended_q && (is_zero || is_delim(text_byte));

		tok_app.chars    = {tok_q.chars[TOK_BITS-9:0], text_byte};
		tok_app.len      = (tok_q.len < TOK_LEN_MAX) ? tok_q.len + 1'b1 : tok_q.len;
		tok_app.too_long = tok_q.too_long || (tok_q.len == TOK_LEN_MAX);

		// At most one token closes per word: the open one on a break,
		// otherwise the one left after this byte when the text ends here.
		if (brk) begin
			tok_sel  = tok_q;
			do_close = 1'b1;
		end else begin
			tok_sel  = ended_q ? tok_q : tok_app;
			do_close = last;
		end

		if (last || brk) begin
			tok_d = '0;
		end else if (ended_q) begin
			tok_d = tok_q;
		end else begin
			tok_d = tok_app;
		end

		for (int k = 0; k < NUM_KW; k++) begin
			hit[k] = do_close && !tok_sel.too_long && (tok_sel.len == KW_LEN[k]) &&
				(tok_sel.chars == KW_CHARS[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= '0;
			ended_q <= 1'b0;
		end else if (advance) begin
			tok_q   <= tok_d;
			ended_q <= !last && (ended_q || (brk && is_zero));
		end
	end

endmodule

FILE: rtl/kwc_counters.sv
`timescale 1ns / 1ps

module kwc_counters import kwc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              last,
	input  logic [NUM_KW-1:0] hit,
	output out_word_t         result
);

	count_t cnt_q [NUM_KW];
	count_t cnt_d [NUM_KW];

	always_comb begin
		for (int k = 0; k < NUM_KW; k++) begin
			cnt_d[k] = (hit[k] && (cnt_q[k] != '1)) ? cnt_q[k] + 1'b1 : cnt_q[k];
		end
		result.count_int    = FIELD_WIDTH'(cnt_d[KW_INT]);
		result.count_return = FIELD_WIDTH'(cnt_d[KW_RETURN]);
		result.count_if     = FIELD_WIDTH'(cnt_d[KW_IF]);
		result.count_else   = FIELD_WIDTH'(cnt_d[KW_ELSE]);
		result.count_while  = FIELD_WIDTH'(cnt_d[KW_WHILE]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_KW; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (advance) begin
			for (int k = 0; k < NUM_KW; k++) begin
				cnt_q[k] <= last ? '0 : cnt_d[k];
			end
		end
	end

endmodule

FILE: rtl/keyword_token_counter.sv
`timescale 1ns / 1ps

// Channel  Handshake                  Word
// text     text_valid / text_stall    in_word_t  {text_byte, end_of_text}
// count    count_valid / count_stall  out_word_t {five keyword counts}
//
// One byte per cycle sustained while text_stall is low.
// The path is input register, tokenizer/matcher plus counter update, result register.
// Reset clears the token, the counts and both valid registers.
// A stalled result holds; only a final byte waiting behind it stalls text,
// other bytes keep flowing.

module keyword_token_counter import kwc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      text_valid,
	output logic      text_stall,
	input  in_word_t  text,
	output logic      count_valid,
	input  logic      count_stall,
	output out_word_t counts
);

	logic              valid_s1;
	in_word_t          word_s1;
	logic              out_free;
	logic              advance;
	logic [NUM_KW-1:0] hit;
	out_word_t         result;

	assign out_free   = !count_valid || !count_stall;
	assign advance    = valid_s1 && (!word_s1.end_of_text || out_free);
	assign text_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!text_stall) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			word_s1 <= text;
		end
	end

	kwc_token u_token (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.text_byte (word_s1.text_byte),
		.last      (word_s1.end_of_text),
		.hit       (hit)
	);

	kwc_counters u_counters (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.last    (word_s1.end_of_text),
		.hit     (hit),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_valid <= 1'b0;
		end else if (out_free) begin
			count_valid <= advance && word_s1.end_of_text;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && word_s1.end_of_text) begin
			counts <= result;
		end
	end

endmodule

FILE: rtl/kwc_checker.sv
`timescale 1ns / 1ps

module kwc_checker import kwc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      text_valid,
	input logic      text_stall,
	input in_word_t  text,
	input logic      count_valid,
	input logic      count_stall,
	input out_word_t counts
);

	// text only backs up behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> (count_valid && count_stall))
		else $error("text stalled without a held result");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(count_valid && count_stall) |=> (count_valid && $stable(counts)))
		else $error("stalled result changed");

	a_reset_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> (!count_valid && !text_stall))
		else $error("handshake not clear after reset");

	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		(text_valid && !text_stall && text.end_of_text) |-> ##2 count_valid)
		else $error("no result after final word");

endmodule

bind keyword_token_counter kwc_checker u_kwc_checker (.*);
